/* design/periodic_task_tick_scheduler_defines.svh */
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PTTS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ptts_pkg.sv */
`default_nettype none

package ptts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 16;
  localparam int STATE_W = 2;
  localparam int OUT_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    OP_TICK        = 3'd0,
    OP_DISPATCH    = 3'd1,
    OP_SET_STATE   = 3'd2,
    OP_SET_PERIOD  = 3'd3,
    OP_SET_COUNTER = 3'd4,
    OP_READ        = 3'd5
  } op_e;

  typedef enum logic [STATE_W-1:0] {
    ST_PAUSED   = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_READY    = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DISP,
    RES_SINGLE
  } res_sel_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_TICK,
    FSM_TICK_RES,
    FSM_DISP,
    FSM_SINGLE
  } fsm_e;

  typedef struct packed {
    logic     capture;
    logic     walk_inc;
    logic     tick_upd;
    logic     disp_upd;
    logic     set_upd;
    logic     emit;
    res_sel_e res_sel;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] new_cmd;
    logic             walk_last;
    logic             cur_ready;
    logic             mask_empty;
    logic             mask_one;
    logic             res_free;
  } stat_t;

endpackage

`default_nettype wire

/* design/ptts_if.sv */
`default_nettype none

interface ptts_in_if;
  import ptts_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] slot_index;
  logic [VAL_W-1:0] write_value;

  modport source (output valid, cmd, slot_index, write_value, input ready);
  modport sink   (input valid, cmd, slot_index, write_value, output ready);
endinterface

interface ptts_out_if;
  import ptts_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   result_slot;
  logic [STATE_W-1:0] slot_state;
  logic [OUT_W-1:0]   slot_period;
  logic [OUT_W-1:0]   slot_counter;
  logic               dispatched;
  logic               error_flag;
  logic               last;

  modport source (output valid, result_slot, slot_state, slot_period, slot_counter,
                  dispatched, error_flag, last, input ready);
  modport sink   (input valid, result_slot, slot_state, slot_period, slot_counter,
                  dispatched, error_flag, last, output ready);
endinterface

`default_nettype wire

/* design/ptts_ctrl.sv */
`default_nettype none

module ptts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ptts_pkg::stat_t stat_i,
  output ptts_pkg::ctrl_t     ctrl_o
);
  import ptts_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          priority if (stat_i.new_cmd == OP_TICK) begin
            state_d = FSM_TICK;
          end else if (stat_i.new_cmd == OP_DISPATCH) begin
            state_d = FSM_DISP;
          end else begin
            state_d = FSM_SINGLE;
          end
        end
      end
      FSM_TICK: begin
        ctrl_o.tick_upd = 1'b1;
        ctrl_o.walk_inc = 1'b1;
        if (stat_i.walk_last) begin
          state_d = FSM_TICK_RES;
        end
      end
      FSM_TICK_RES: begin
        ctrl_o.res_sel = RES_ZERO;
        if (stat_i.res_free) begin
          ctrl_o.emit = 1'b1;
          state_d     = FSM_IDLE;
        end
      end
      FSM_DISP: begin
        priority if (stat_i.mask_empty) begin
          ctrl_o.res_sel = RES_ZERO;
          if (stat_i.res_free) begin
            ctrl_o.emit = 1'b1;
            state_d     = FSM_IDLE;
          end
        end else if (stat_i.cur_ready) begin
          ctrl_o.res_sel = RES_DISP;
          if (stat_i.res_free) begin
            ctrl_o.emit     = 1'b1;
            ctrl_o.disp_upd = 1'b1;
            ctrl_o.walk_inc = 1'b1;
            if (stat_i.mask_one) begin
              state_d = FSM_IDLE;
            end
          end
        end else begin
          ctrl_o.walk_inc = 1'b1;
        end
      end
      FSM_SINGLE: begin
        ctrl_o.res_sel = RES_SINGLE;
        if (stat_i.res_free) begin
          ctrl_o.emit    = 1'b1;
          ctrl_o.set_upd = 1'b1;
          state_d        = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ptts_dp.sv */
`default_nettype none

module ptts_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ptts_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [ptts_pkg::IDX_W-1:0]   slot_index_i,
  input  wire logic [ptts_pkg::VAL_W-1:0]   write_value_i,
  input  wire ptts_pkg::ctrl_t              ctrl_i,
  output ptts_pkg::stat_t                   stat_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ptts_pkg::IDX_W-1:0]        result_slot_o,
  output logic [ptts_pkg::STATE_W-1:0]      slot_state_o,
  output logic [ptts_pkg::OUT_W-1:0]        slot_period_o,
  output logic [ptts_pkg::OUT_W-1:0]        slot_counter_o,
  output logic                              dispatched_o,
  output logic                              error_flag_o,
  output logic                              last_o
);
  import ptts_pkg::*;

  // captured item
  logic [CMD_W-1:0] op_q;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] val_q;

  logic [SLOT_W-1:0]    walk_q;
  logic [NUM_SLOTS-1:0] mask_q;
  logic [NUM_SLOTS-1:0] walk_oh;

  // slot tables
  logic [STATE_W-1:0]   state_q   [NUM_SLOTS];
  logic [TIME_BITS-1:0] period_q  [NUM_SLOTS];
  logic [TIME_BITS-1:0] counter_q [NUM_SLOTS];

  logic [SLOT_W-1:0]    addr;
  logic                 use_idx;
  logic [STATE_W-1:0]   rd_state, nx_state;
  logic [TIME_BITS-1:0] rd_period, nx_period;
  logic [TIME_BITS-1:0] rd_counter, nx_counter;
  logic                 bad_cmd, bad_req, wr_en;

  logic               out_valid_q;
  logic [IDX_W-1:0]   res_slot;
  logic [STATE_W-1:0] res_state;
  logic [OUT_W-1:0]   res_period, res_counter;
  logic               res_disp, res_err, res_last;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      op_q  <= cmd_i;
      idx_q <= slot_index_i;
      val_q <= write_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
      mask_q <= '0;
    end else begin
      if (ctrl_i.capture) begin
        walk_q <= '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          mask_q[i] <= (state_q[i] == ST_READY);
        end
      end else begin
        if (ctrl_i.walk_inc) begin
          walk_q <= walk_q + SLOT_W'(1);
        end
        if (ctrl_i.disp_upd) begin
          mask_q <= mask_q & ~walk_oh;
        end
      end
    end
  end

  assign walk_oh = NUM_SLOTS'(1) << walk_q;

  assign use_idx    = (op_q != OP_TICK) && (op_q != OP_DISPATCH);
  assign addr       = use_idx ? idx_q[SLOT_W-1:0] : walk_q;
  assign rd_state   = state_q[addr];
  assign rd_period  = period_q[addr];
  assign rd_counter = counter_q[addr];

  assign bad_cmd = (op_q > OP_READ);
  assign bad_req = bad_cmd || (idx_q >= IDX_W'(NUM_SLOTS)) ||
                   ((op_q == OP_SET_STATE) && (val_q > VAL_W'(ST_READY)));

  always_comb begin
    nx_state   = rd_state;
    nx_period  = rd_period;
    nx_counter = rd_counter;
    if (ctrl_i.tick_upd) begin
      if (rd_state != ST_PAUSED) begin
        if ((rd_period == '0) || (rd_counter >= rd_period)) begin
          nx_counter = TIME_BITS'(1);
          nx_state   = ST_READY;
        end else begin
          nx_counter = rd_counter + TIME_BITS'(1);
        end
      end
    end else if (ctrl_i.disp_upd) begin
      nx_state = (rd_period == '0) ? ST_PAUSED : ST_RUNNABLE;
    end else if (ctrl_i.set_upd) begin
      unique case (op_q)
        OP_SET_STATE: begin
          nx_state = val_q[STATE_W-1:0];
          if (val_q == VAL_W'(ST_PAUSED)) begin
            nx_counter = TIME_BITS'(1);
          end
        end
        OP_SET_PERIOD:  nx_period  = TIME_BITS'(val_q);
        OP_SET_COUNTER: nx_counter = TIME_BITS'(val_q);
        default: ;
      endcase
    end
  end

  assign wr_en = ctrl_i.tick_upd || ctrl_i.disp_upd || (ctrl_i.set_upd && !bad_req);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_q[i]   <= ST_PAUSED;
        period_q[i]  <= '0;
        counter_q[i] <= TIME_BITS'(1);
      end
    end else if (wr_en) begin
      state_q[addr]   <= nx_state;
      period_q[addr]  <= nx_period;
      counter_q[addr] <= nx_counter;
    end
  end

  // result selection
  always_comb begin
    res_slot    = '0;
    res_state   = '0;
    res_period  = '0;
    res_counter = '0;
    res_disp    = 1'b0;
    res_err     = 1'b0;
    res_last    = 1'b1;
    unique case (ctrl_i.res_sel)
      RES_DISP: begin
        res_slot    = IDX_W'(walk_q);
        res_state   = nx_state;
        res_period  = OUT_W'(nx_period);
        res_counter = OUT_W'(nx_counter);
        res_disp    = 1'b1;
        res_last    = stat_o.mask_one;
      end
      RES_SINGLE: begin
        priority if (bad_cmd) begin
          res_err = 1'b1;
        end else if (bad_req) begin
          res_slot = idx_q;
          res_err  = 1'b1;
        end else begin
          res_slot    = idx_q;
          res_state   = nx_state;
          res_period  = OUT_W'(nx_period);
          res_counter = OUT_W'(nx_counter);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      result_slot_o  <= res_slot;
      slot_state_o   <= res_state;
      slot_period_o  <= res_period;
      slot_counter_o <= res_counter;
      dispatched_o   <= res_disp;
      error_flag_o   <= res_err;
      last_o         <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.new_cmd    = cmd_i;
  assign stat_o.walk_last  = (walk_q == SLOT_W'(NUM_SLOTS - 1));
  assign stat_o.cur_ready  = |(mask_q & walk_oh);
  assign stat_o.mask_empty = (mask_q == '0);
  assign stat_o.mask_one   = ((mask_q & ~walk_oh) == '0);
  assign stat_o.res_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* design/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler: NUM_SLOTS task slots, each with a state, a period and a tick
// counter, driven by one command item at a time. The block takes an item only when idle and
// works on it alone. A tick walks the slots one per clock, then loads a single result with
// no slot contents. A dispatch walks the same way and emits one result per ready slot (one
// empty result if none is ready), stopping after the last ready slot. Set and read commands
// emit one result each. One output register holds the current result; while it is not
// taken, the walk waits on the next result.
`default_nettype none

module periodic_task_tick_scheduler (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptts_in_if.sink   in_i,
  ptts_out_if.source out_o
);
  import ptts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ptts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ptts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (in_i.cmd),
    .slot_index_i   (in_i.slot_index),
    .write_value_i  (in_i.write_value),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_slot_o  (out_o.result_slot),
    .slot_state_o   (out_o.slot_state),
    .slot_period_o  (out_o.slot_period),
    .slot_counter_o (out_o.slot_counter),
    .dispatched_o   (out_o.dispatched),
    .error_flag_o   (out_o.error_flag),
    .last_o         (out_o.last)
  );

endmodule

`default_nettype wire

/* design/ptts_checker.sv */
`default_nettype none

`include "periodic_task_tick_scheduler_defines.svh"

module ptts_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [ptts_pkg::STATE_W-1:0]   slot_state_i,
  input wire logic [ptts_pkg::OUT_W-1:0]     slot_period_i,
  input wire logic [ptts_pkg::OUT_W-1:0]     slot_counter_i,
  input wire logic                           dispatched_i,
  input wire logic                           error_flag_i
);
  import ptts_pkg::*;

  // a stalled result stays offered
  `PTTS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // each item is worked on alone
  `PTTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i,
                    "item taken while busy")

  // a dispatched slot has left the ready state and carries no error
  `PTTS_ASSERT(a_disp_moved, out_valid_i && dispatched_i,
               (slot_state_i != ST_READY) && !error_flag_i, "bad dispatch result")

  // error results carry no slot contents
  `PTTS_ASSERT(a_err_clean, out_valid_i && error_flag_i,
               !dispatched_i && (slot_state_i == ST_PAUSED) && (slot_period_i == '0) &&
               (slot_counter_i == '0), "error result not cleared")

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .slot_state_i   (out_o.slot_state),
  .slot_period_i  (out_o.slot_period),
  .slot_counter_i (out_o.slot_counter),
  .dispatched_i   (out_o.dispatched),
  .error_flag_i   (out_o.error_flag)
);

`default_nettype wire
